// ===== sv/tcec_pkg.sv =====
// shared types, codes and constants of the text console escape/cursor engine
`default_nettype none

package tcec_pkg;

	// default geometry
	localparam int MAX_COLS_DEF     = 256;
	localparam int MAX_ROWS_DEF     = 128;
	localparam int GLYPH_WIDTH_DEF  = 8;
	localparam int GLYPH_HEIGHT_DEF = 16;

	// command queue depth (power of two)
	localparam int QUEUE_DEPTH = 4;

	// configuration register indexes
	localparam logic [2:0] REG_SCREEN_READY = 3'd0;
	localparam logic [2:0] REG_COLUMNS      = 3'd1;
	localparam logic [2:0] REG_TEXT_ROWS    = 3'd2;
	localparam logic [2:0] REG_BACKGROUND   = 3'd3;
	localparam logic [2:0] REG_MINI_MODE    = 3'd4;
	localparam logic [2:0] REG_MINI_KEEP    = 3'd5;

	// configuration reset values
	localparam logic [8:0] COLUMNS_RST   = 9'd80;
	localparam logic [7:0] TEXT_ROWS_RST = 8'd30;
	localparam logic [6:0] MINI_KEEP_RST = 7'd4;

	// character codes
	localparam logic [7:0] CH_TAB      = 8'd9;
	localparam logic [7:0] CH_NEWLINE  = 8'd10;
	localparam logic [7:0] CH_ESC      = 8'd27;
	localparam logic [7:0] CH_ZERO     = 8'd48;
	localparam logic [7:0] CH_TWO      = 8'd50;
	localparam logic [7:0] CH_J        = 8'd74;
	localparam logic [7:0] CH_LBRACKET = 8'd91;

	// color select codes
	localparam logic [11:0] SGR_RED   = 12'd31;
	localparam logic [11:0] SGR_GREEN = 12'd32;
	localparam logic [11:0] SGR_WHITE = 12'd39;
	localparam logic [11:0] SGR_CYAN  = 12'd96;

	// foreground palette
	localparam logic [1:0] FG_WHITE = 2'd0;
	localparam logic [1:0] FG_RED   = 2'd1;
	localparam logic [1:0] FG_GREEN = 2'd2;
	localparam logic [1:0] FG_CYAN  = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_DRAW       = 2'd0;
	localparam logic [1:0] KIND_CLR_SCREEN = 2'd1;
	localparam logic [1:0] KIND_CLR_MINI   = 2'd2;
	localparam logic [1:0] KIND_NOT_READY  = 2'd3;

	// commands from parser to cursor engine
	typedef enum logic [1:0] {
		CMD_DRAW,
		CMD_CLEAR,
		CMD_NOT_READY
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t    op;
		logic [7:0] glyph;
		logic [1:0] fg;
	} cmd_t;

	// configuration seen by the cursor engine
	typedef struct packed {
		logic [8:0]  columns;
		logic [7:0]  text_rows;
		logic [31:0] background_color;
		logic        minishell_mode;
		logic [6:0]  minishell_keep_rows;
	} cfg_t;

endpackage

`default_nettype wire

// ===== sv/text_console_escape_cursor.sv =====
// Text console character engine. One character beat is taken on the input
// channel; a parser recognizes ESC [ 2 J (screen clear) and ESC [ x ; d d m
// (foreground color select), and every other byte becomes a draw beat at the
// pixel position of the text cursor, followed by a clear beat when the cursor
// runs off the bottom. The parser accepts a character every cycle as long as
// its four-entry command queue has room; the cursor engine behind it retires
// one command per cycle while no clear is pending and the output is free; a
// draw that overflows the screen gives a draw beat, then a clear beat, from
// the single output register. Escape bytes make no beats. When screen_ready is
// low every character gives one not-ready beat. Configuration is written
// through cfg_we/cfg_index/cfg_data and should only change while idle.
`default_nettype none

module text_console_escape_cursor #(
	parameter int MAX_COLS     = tcec_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS     = tcec_pkg::MAX_ROWS_DEF,
	parameter int GLYPH_WIDTH  = tcec_pkg::GLYPH_WIDTH_DEF,
	parameter int GLYPH_HEIGHT = tcec_pkg::GLYPH_HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  char_code,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       glyph,
	output logic [11:0]      x_pixel,
	output logic [11:0]      y_pixel,
	output logic [1:0]       fg_index,
	output logic [31:0]      fill_color,
	output logic             last
);

	logic           screen_ready_q;
	tcec_pkg::cfg_t cfg_q;
	logic           q_full;
	logic           q_push;
	tcec_pkg::cmd_t q_cmd;
	logic           q_pop;
	logic           q_not_empty;
	tcec_pkg::cmd_t q_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_ready_q            <= 1'b0;
			cfg_q.columns             <= tcec_pkg::COLUMNS_RST;
			cfg_q.text_rows           <= tcec_pkg::TEXT_ROWS_RST;
			cfg_q.background_color    <= 32'd0;
			cfg_q.minishell_mode      <= 1'b0;
			cfg_q.minishell_keep_rows <= tcec_pkg::MINI_KEEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tcec_pkg::REG_SCREEN_READY: screen_ready_q <= cfg_data[0];
				tcec_pkg::REG_COLUMNS:      cfg_q.columns <= cfg_data[8:0];
				tcec_pkg::REG_TEXT_ROWS:    cfg_q.text_rows <= cfg_data[7:0];
				tcec_pkg::REG_BACKGROUND:   cfg_q.background_color <= cfg_data;
				tcec_pkg::REG_MINI_MODE:    cfg_q.minishell_mode <= cfg_data[0];
				tcec_pkg::REG_MINI_KEEP:    cfg_q.minishell_keep_rows <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// parser
	tcec_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.char_code    (char_code),
		.screen_ready (screen_ready_q),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_cmd        (q_cmd)
	);

	// command queue
	tcec_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (q_head)
	);

	// cursor engine
	tcec_back #(
		.MAX_COLS     (MAX_COLS),
		.MAX_ROWS     (MAX_ROWS),
		.GLYPH_WIDTH  (GLYPH_WIDTH),
		.GLYPH_HEIGHT (GLYPH_HEIGHT)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.cmd_valid  (q_not_empty),
		.cmd        (q_head),
		.cmd_pop    (q_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.kind       (kind),
		.glyph      (glyph),
		.x_pixel    (x_pixel),
		.y_pixel    (y_pixel),
		.fg_index   (fg_index),
		.fill_color (fill_color),
		.last       (last)
	);

endmodule

`default_nettype wire

// ===== sv/tcec_front.sv =====
// front end: takes character beats, runs the escape parser, issues commands
`default_nettype none

module tcec_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire logic [7:0]     char_code,
	input  wire logic           screen_ready,
	input  wire logic           q_full,
	output logic                q_push,
	output tcec_pkg::cmd_t      q_cmd
);

	typedef enum logic [2:0] {
		PS_NORMAL,
		PS_ESCAPE,
		PS_BRACKET,
		PS_CLEAR,
		PS_SKIP,
		PS_DIGIT1,
		PS_DIGIT2,
		PS_FINAL
	} ps_t;

	ps_t         state_q, state_n;
	logic        skip_q, skip_n;
	logic [11:0] tens_q, tens_n;
	logic [11:0] units_q, units_n;
	logic [1:0]  fg_q, fg_n;
	logic        accept;
	logic        push_n;
	logic        draw_it;
	logic [11:0] digit;
	logic [11:0] digit_x10;
	logic [11:0] code;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// digit arithmetic, modulo 4096
	assign digit     = {4'd0, char_code} - {4'd0, tcec_pkg::CH_ZERO};
	assign digit_x10 = (digit << 3) + (digit << 1);
	assign code      = tens_q + units_q;

	// parser next state and command
	always_comb begin
		state_n   = state_q;
		skip_n    = skip_q;
		tens_n    = tens_q;
		units_n   = units_q;
		fg_n      = fg_q;
		push_n    = 1'b0;
		draw_it   = 1'b0;
		q_cmd.op    = tcec_pkg::CMD_DRAW;
		q_cmd.glyph = char_code;
		q_cmd.fg    = fg_q;
		if (!screen_ready) begin
			push_n   = 1'b1;
			q_cmd.op = tcec_pkg::CMD_NOT_READY;
		end else if (char_code == tcec_pkg::CH_ESC) begin
			state_n = PS_ESCAPE;
			skip_n  = 1'b0;
		end else begin
			case (state_q)
				PS_ESCAPE: begin
					if (char_code == tcec_pkg::CH_LBRACKET) begin
						state_n = PS_BRACKET;
					end else begin
						draw_it = 1'b1;
					end
				end
				PS_BRACKET: begin
					state_n = (char_code == tcec_pkg::CH_TWO) ? PS_CLEAR : PS_SKIP;
				end
				PS_CLEAR: begin
					if (char_code == tcec_pkg::CH_J) begin
						push_n   = 1'b1;
						q_cmd.op = tcec_pkg::CMD_CLEAR;
						state_n  = PS_NORMAL;
					end else begin
						draw_it = 1'b1;
					end
				end
				PS_SKIP: begin
					if (!skip_q) begin
						skip_n = 1'b1;
					end else begin
						skip_n  = 1'b0;
						tens_n  = digit_x10;
						state_n = PS_DIGIT2;
					end
				end
				PS_DIGIT1: begin
					tens_n  = digit_x10;
					state_n = PS_DIGIT2;
				end
				PS_DIGIT2: begin
					units_n = digit;
					state_n = PS_FINAL;
				end
				PS_FINAL: begin
					if (code == tcec_pkg::SGR_RED) begin
						fg_n    = tcec_pkg::FG_RED;
						state_n = PS_NORMAL;
					end else if (code == tcec_pkg::SGR_GREEN) begin
						fg_n    = tcec_pkg::FG_GREEN;
						state_n = PS_NORMAL;
					end else if (code == tcec_pkg::SGR_WHITE) begin
						fg_n    = tcec_pkg::FG_WHITE;
						state_n = PS_NORMAL;
					end else if (code == tcec_pkg::SGR_CYAN) begin
						fg_n    = tcec_pkg::FG_CYAN;
						state_n = PS_NORMAL;
					end else begin
						draw_it = 1'b1;
					end
				end
				default: begin
					draw_it = 1'b1;
				end
			endcase
			if (draw_it) begin
				state_n = PS_NORMAL;
				push_n  = 1'b1;
			end
		end
	end

	assign q_push = accept && push_n;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_NORMAL;
			skip_q  <= 1'b0;
			tens_q  <= 12'd0;
			units_q <= 12'd0;
			fg_q    <= tcec_pkg::FG_WHITE;
		end else if (accept) begin
			state_q <= state_n;
			skip_q  <= skip_n;
			tens_q  <= tens_n;
			units_q <= units_n;
			fg_q    <= fg_n;
		end
	end

	// a completed clear sequence leaves the parser in normal state
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_cmd.op == tcec_pkg::CMD_CLEAR) |=> (state_q == PS_NORMAL))
		else $error("parser not back to normal after clear sequence");

endmodule

`default_nettype wire

// ===== sv/tcec_queue.sv =====
// short command queue between parser and cursor engine
`default_nettype none

module tcec_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire tcec_pkg::cmd_t push_cmd,
	output logic                full,
	input  wire logic           pop,
	output logic                not_empty,
	output tcec_pkg::cmd_t      head
);

	localparam int DEPTH = tcec_pkg::QUEUE_DEPTH;
	localparam int AW    = $clog2(DEPTH);

	tcec_pkg::cmd_t entries_q [DEPTH];
	logic [AW-1:0]  wr_ptr_q;
	logic [AW-1:0]  rd_ptr_q;
	logic [AW:0]    count_q;
	logic           do_push;
	logic           do_pop;

	assign full      = (count_q == (AW+1)'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head      = entries_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// fill level never passes the depth
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (AW+1)'(DEPTH))
		else $error("command queue overflow");

endmodule

`default_nettype wire

// ===== sv/tcec_back.sv =====
// back end: cursor engine that turns commands into result beats
`default_nettype none

module tcec_back #(
	parameter int MAX_COLS     = tcec_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS     = tcec_pkg::MAX_ROWS_DEF,
	parameter int GLYPH_WIDTH  = tcec_pkg::GLYPH_WIDTH_DEF,
	parameter int GLYPH_HEIGHT = tcec_pkg::GLYPH_HEIGHT_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tcec_pkg::cfg_t cfg,
	input  wire logic           cmd_valid,
	input  wire tcec_pkg::cmd_t cmd,
	output logic                cmd_pop,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [1:0]          kind,
	output logic [7:0]          glyph,
	output logic [11:0]         x_pixel,
	output logic [11:0]         y_pixel,
	output logic [1:0]          fg_index,
	output logic [31:0]         fill_color,
	output logic                last
);

	logic        out_valid_q;
	logic        pend_q;
	logic [1:0]  pend_kind_q;
	logic [8:0]  cursor_x_q;
	logic [7:0]  cursor_y_q;
	logic [1:0]  kind_q;
	logic [7:0]  glyph_q;
	logic [11:0] x_pixel_q;
	logic [11:0] y_pixel_q;
	logic [1:0]  fg_q;
	logic [31:0] fill_q;
	logic        last_q;

	logic        out_free;
	logic        load_pend;
	logic [8:0]  cols_c;
	logic [7:0]  rows_c;
	logic [6:0]  keep_c;
	logic [8:0]  cx_a;
	logic [7:0]  cy_a;
	logic [11:0] xp;
	logic [11:0] yp;
	logic [8:0]  cx_b;
	logic        wrap;
	logic [8:0]  cx_c;
	logic [7:0]  cy_c;
	logic        ovf;
	logic [7:0]  cy_mini;
	logic [7:0]  cy_bottom;

	assign out_free  = !out_valid_q || out_ready;
	assign cmd_pop   = cmd_valid && !pend_q && out_free;
	assign load_pend = pend_q && out_free;

	// clamp the geometry registers
	always_comb begin
		if (cfg.columns == 9'd0) begin
			cols_c = 9'd1;
		end else if (cfg.columns > 9'(MAX_COLS)) begin
			cols_c = 9'(MAX_COLS);
		end else begin
			cols_c = cfg.columns;
		end
		if (cfg.text_rows == 8'd0) begin
			rows_c = 8'd1;
		end else if (cfg.text_rows > 8'(MAX_ROWS)) begin
			rows_c = 8'(MAX_ROWS);
		end else begin
			rows_c = cfg.text_rows;
		end
		keep_c = (cfg.minishell_keep_rows == 7'd0) ? 7'd1 : cfg.minishell_keep_rows;
	end

	// newline and tab move the cursor before the draw
	always_comb begin
		cx_a = cursor_x_q;
		cy_a = cursor_y_q;
		if (cmd.glyph == tcec_pkg::CH_NEWLINE) begin
			cy_a = cursor_y_q + 8'd1;
			cx_a = 9'd0;
		end else if (cmd.glyph == tcec_pkg::CH_TAB) begin
			cx_a = cursor_x_q + 9'd4;
		end
	end

	// pixel position, then advance with wrap and bottom check
	assign xp        = {3'd0, cx_a} * 12'(GLYPH_WIDTH);
	assign yp        = {4'd0, cy_a} * 12'(GLYPH_HEIGHT);
	assign cx_b      = cx_a + 9'd1;
	assign wrap      = (cx_b >= cols_c);
	assign cx_c      = wrap ? 9'd0 : cx_b;
	assign cy_c      = wrap ? (cy_a + 8'd1) : cy_a;
	assign ovf       = (cy_c >= rows_c);
	assign cy_mini   = (rows_c > {1'b0, keep_c}) ? (rows_c - {1'b0, keep_c}) : 8'd0;
	assign cy_bottom = cfg.minishell_mode ? cy_mini : 8'd0;

	// control: output valid, pending clear and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			pend_kind_q <= tcec_pkg::KIND_CLR_SCREEN;
			cursor_x_q  <= 9'd0;
			cursor_y_q  <= 8'd0;
		end else begin
			if (cmd_pop) begin
				out_valid_q <= 1'b1;
				case (cmd.op)
					tcec_pkg::CMD_CLEAR: begin
						cursor_y_q <= 8'd0;
					end
					tcec_pkg::CMD_DRAW: begin
						cursor_x_q  <= cx_c;
						cursor_y_q  <= ovf ? cy_bottom : cy_c;
						pend_q      <= ovf;
						pend_kind_q <= cfg.minishell_mode ? tcec_pkg::KIND_CLR_MINI
						                                  : tcec_pkg::KIND_CLR_SCREEN;
					end
					default: begin
						pend_q <= 1'b0;
					end
				endcase
			end else if (load_pend) begin
				out_valid_q <= 1'b1;
				pend_q      <= 1'b0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			glyph_q   <= 8'd0;
			x_pixel_q <= 12'd0;
			y_pixel_q <= 12'd0;
			fg_q      <= 2'd0;
			fill_q    <= 32'd0;
			last_q    <= 1'b1;
			case (cmd.op)
				tcec_pkg::CMD_CLEAR: begin
					kind_q <= tcec_pkg::KIND_CLR_SCREEN;
					fill_q <= cfg.background_color;
				end
				tcec_pkg::CMD_DRAW: begin
					kind_q    <= tcec_pkg::KIND_DRAW;
					glyph_q   <= cmd.glyph;
					x_pixel_q <= xp;
					y_pixel_q <= yp;
					fg_q      <= cmd.fg;
					last_q    <= !ovf;
				end
				default: begin
					kind_q <= tcec_pkg::KIND_NOT_READY;
				end
			endcase
		end else if (load_pend) begin
			kind_q    <= pend_kind_q;
			glyph_q   <= 8'd0;
			x_pixel_q <= 12'd0;
			y_pixel_q <= 12'd0;
			fg_q      <= 2'd0;
			fill_q    <= cfg.background_color;
			last_q    <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign glyph      = glyph_q;
	assign x_pixel    = x_pixel_q;
	assign y_pixel    = y_pixel_q;
	assign fg_index   = fg_q;
	assign fill_color = fill_q;
	assign last       = last_q;

	// a pending clear always sits behind a shown draw beat
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> out_valid_q)
		else $error("pending clear without a shown draw beat");

	// a beat that is not last must have its clear queued up
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !last_q) |-> (pend_q && kind_q == tcec_pkg::KIND_DRAW))
		else $error("non-final beat without pending clear");

	// no command is taken while a clear is still owed
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !cmd_pop)
		else $error("command taken ahead of pending clear");

endmodule

`default_nettype wire
